FILE: hw/rtl/grb_pkg.sv
// ----------------------------------------------------------------------------
// grb_pkg
// Shared types and constants of the gray row box blur.
// ----------------------------------------------------------------------------
package grb_pkg;

	// window limits
	localparam int MAX_RADIUS = 15;
	localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int RAD_W      = 4;
	localparam int GRAY_W     = 8;
	localparam int SUM_W      = 13;
	localparam int DIV_STEPS  = GRAY_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// gray weights in Q0.16
	localparam logic [15:0] W0 = 16'd19595;
	localparam logic [15:0] W1 = 16'd37356;
	localparam logic [15:0] W2 = 16'd8585;

	// command queue
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);

	// word classes
	localparam logic [1:0] K_FILL   = 2'd0; // window not yet full, no mean
	localparam logic [1:0] K_FIRST  = 2'd1; // word that fills the window
	localparam logic [1:0] K_STEADY = 2'd2; // window full, slide by one

	// command from front to back
	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic [1:0]        kind;
		logic              eor;
		logic [PTR_W-1:0]  cnt;   // pixels of the row so far, saturating
	} cmd_t;

	// configuration seen by front and back
	typedef struct packed {
		logic             clear;
		logic [RAD_W-1:0] radius;
		logic [PTR_W-1:0] win_len;
	} ctl_t;

endpackage

FILE: hw/rtl/grb_ram.sv
// ----------------------------------------------------------------------------
// grb_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module grb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/grb_front.sv
// ----------------------------------------------------------------------------
// grb_front
// Accepts pixels, converts to gray and classifies each word against the
// row fill count before handing it to the command queue.
// ----------------------------------------------------------------------------
module grb_front
	import grb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  first_channel,
	input  logic [7:0]  second_channel,
	input  logic [7:0]  third_channel,
	input  logic        end_of_row,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_data
);

	logic [PTR_W-1:0] fill_q;
	logic [PTR_W-1:0] fill_inc;
	logic             filling;
	logic [23:0]      gray_acc;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// weighted sum; weights total 65536 so the top byte never overflows
	assign gray_acc = 24'(first_channel)  * 24'(W0)
	                + 24'(second_channel) * 24'(W1)
	                + 24'(third_channel)  * 24'(W2);

	// classification
	assign filling  = fill_q < ctl.win_len;
	assign fill_inc = filling ? fill_q + PTR_W'(1) : fill_q;

	always_comb begin
		q_data.gray = gray_acc[23:16];
		q_data.eor  = end_of_row;
		q_data.cnt  = fill_inc;
		if (!filling) begin
			q_data.kind = K_STEADY;
		end else if (fill_inc == ctl.win_len) begin
			q_data.kind = K_FIRST;
		end else begin
			q_data.kind = K_FILL;
		end
	end

	// row fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.clear) begin
			fill_q <= '0;
		end else if (q_push) begin
			fill_q <= end_of_row ? '0 : fill_inc;
		end
	end

endmodule

FILE: hw/rtl/grb_queue.sv
// ----------------------------------------------------------------------------
// grb_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module grb_queue
	import grb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t              ent_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W+1)'(Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = ent_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/grb_back.sv
// ----------------------------------------------------------------------------
// grb_back
// Executes commands: ring update, running sum, shared bit-serial divider
// and the result burst into the output register.
// ----------------------------------------------------------------------------
module grb_back
	import grb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic              q_valid,
	input  cmd_t              q_head,
	output logic              q_pop,
	output logic              ram_wr_en,
	output logic [PTR_W-1:0]  ram_wr_addr,
	output logic [GRAY_W-1:0] ram_wr_data,
	output logic              ram_rd_en,
	output logic [PTR_W-1:0]  ram_rd_addr,
	input  logic [GRAY_W-1:0] ram_rd_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        blurred_gray,
	output logic              row_done,
	output logic              run_last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]        state_q;
	cmd_t              cmd_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  den_q;
	logic [GRAY_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [PTR_W-1:0]  emit_cnt_q;
	logic              out_valid_q;

	logic [PTR_W-1:0]  slot;
	logic [PTR_W-1:0]  slot_inc;
	logic [SUM_W-1:0]  sum_new;
	logic [PTR_W-1:0]  divisor;
	logic [PTR_W-1:0]  tail_cnt;
	logic [PTR_W-1:0]  burst_cnt;
	logic              need_div;
	logic              ge;
	logic              load_out;
	logic              last_word;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// ring slot and next pointer
	assign slot     = (ptr_q < ctl.win_len) ? ptr_q : '0;
	assign slot_inc = slot + PTR_W'(1);

	// running sum: drop the oldest gray only once the window is full
	assign sum_new = sum_q + SUM_W'(cmd_q.gray)
	               - ((cmd_q.kind == K_STEADY) ? SUM_W'(ram_rd_data) : '0);

	// ring RAM ports
	assign ram_rd_en   = state_q == ST_READ;
	assign ram_rd_addr = slot;
	assign ram_wr_en   = state_q == ST_UPD;
	assign ram_wr_addr = slot;
	assign ram_wr_data = cmd_q.gray;

	// burst length and divisor
	assign tail_cnt = cmd_q.eor ? PTR_W'(ctl.radius) : '0;
	assign need_div = (cmd_q.kind != K_FILL) || cmd_q.eor;
	assign divisor  = (cmd_q.kind == K_FILL) ? cmd_q.cnt : ctl.win_len;

	always_comb begin
		case (cmd_q.kind)
			K_FIRST:  burst_cnt = PTR_W'(ctl.radius) + PTR_W'(1) + tail_cnt;
			K_STEADY: burst_cnt = PTR_W'(1) + tail_cnt;
			default:  burst_cnt = cmd_q.cnt;
		endcase
	end

	// restoring division step, quotient MSB first
	assign ge = rem_q >= den_q;

	// output register handshake
	assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign last_word = emit_cnt_q == PTR_W'(1);

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			ptr_q       <= '0;
			step_q      <= '0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (ctl.clear) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word takes the register, else a taken word frees it
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					sum_q      <= sum_new;
					ptr_q      <= (slot_inc >= ctl.win_len) ? '0 : slot_inc;
					step_q     <= STEP_W'(DIV_STEPS - 1);
					emit_cnt_q <= burst_cnt;
					state_q    <= need_div ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						emit_cnt_q  <= emit_cnt_q - PTR_W'(1);
						if (last_word) begin
							state_q <= ST_IDLE;
							if (cmd_q.eor) begin
								sum_q <= '0;
								ptr_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (state_q == ST_UPD) begin
			rem_q <= sum_new;
			den_q <= SUM_W'(divisor) << (DIV_STEPS - 1);
		end else if (state_q == ST_DIV) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[GRAY_W-2:0], ge};
		end
		if (load_out) begin
			blurred_gray <= quo_q;
			row_done     <= last_word && cmd_q.eor;
			run_last     <= last_word;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/gray_row_box_blur.sv
// ----------------------------------------------------------------------------
// gray_row_box_blur
// Horizontal box blur of gray pixels converted from three-channel input.
// ----------------------------------------------------------------------------
// Input words (first/second/third_channel, end_of_row) arrive in row order
// on a valid/ready channel; end_of_row marks a row's last pixel. Each pixel
// yields zero or more output words (blurred_gray, row_done, run_last) on a
// valid/ready channel; run_last flags the last word caused by one pixel,
// row_done the final word of a row.
// The front converts and classifies pixels into a two-entry queue; the back
// reads the ring RAM, updates the running sum and runs an 8-step bit-serial
// divider before its burst. It pops a pixel from the queue only when idle,
// so it is through with one pixel before it takes the next; a pixel that
// gives no word skips the divider.
// cfg_we with cfg_wdata sets the radius (window 2r+1) and starts a new row;
// write only while idle. Reset sets the radius to 5 and clears the row state;
// the ring needs no clearing pass. When the receiver stalls, the output word
// holds, the back waits and the queue fills, after which in_ready drops.
// ----------------------------------------------------------------------------
module gray_row_box_blur
	import grb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] first_channel,
	input  logic [7:0] second_channel,
	input  logic [7:0] third_channel,
	input  logic       end_of_row,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] blurred_gray,
	output logic       row_done,
	output logic       run_last
);

	logic [RAD_W-1:0]  radius_q;
	logic [RAD_W-1:0]  radius_eff;
	ctl_t              ctl;
	logic              q_full;
	logic              q_push;
	cmd_t              q_data;
	logic              q_pop;
	logic              q_valid;
	cmd_t              q_head;
	logic              ram_wr_en;
	logic [PTR_W-1:0]  ram_wr_addr;
	logic [GRAY_W-1:0] ram_wr_data;
	logic              ram_rd_en;
	logic [PTR_W-1:0]  ram_rd_addr;
	logic [GRAY_W-1:0] ram_rd_data;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(5);
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// saturated radius and window length
	assign radius_eff  = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
	assign ctl.clear   = cfg_we;
	assign ctl.radius  = radius_eff;
	assign ctl.win_len = {radius_eff, 1'b1};

	grb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_channel  (first_channel),
		.second_channel (second_channel),
		.third_channel  (third_channel),
		.end_of_row     (end_of_row),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_data)
	);

	grb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	grb_ram #(
		.WIDTH (GRAY_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	grb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.ram_wr_en    (ram_wr_en),
		.ram_wr_addr  (ram_wr_addr),
		.ram_wr_data  (ram_wr_data),
		.ram_rd_en    (ram_rd_en),
		.ram_rd_addr  (ram_rd_addr),
		.ram_rd_data  (ram_rd_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.blurred_gray (blurred_gray),
		.row_done     (row_done),
		.run_last     (run_last)
	);

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the gray row box blur against its own predictor. Pixels go in over
// a valid/ready channel in row order. Each accepted pixel is turned into the
// blurred words that it should cause, and these are queued. The output
// monitor compares every received word, field by field, with the oldest word
// in that queue. The run starts with a table of hand-picked pixels and then
// goes through phases of random rows, one radius per phase, with random gaps
// on both sides in most phases, a long output stall in some and a full drain.
// ----------------------------------------------------------------------------
module testbench;
	import grb_pkg::*;

	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int SETTLE_CYCLES   = 40;   // covers the back end's latency
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int N_DIRECTED      = 22;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic       eor;
	} pixel_t;

	typedef struct packed {
		logic [7:0] gray;
		logic       row_done;
		logic       run_last;
	} blur_word_t;

	// directed row: a pixel and, where obvious, the gray of all its words
	typedef struct packed {
		pixel_t     px;
		logic       typed;
		logic [7:0] gray;
	} directed_row_t;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       cfg_we         = 1'b0;
	logic [3:0] cfg_wdata      = 4'd0;
	logic       in_valid       = 1'b0;
	logic       in_ready;
	logic [7:0] first_channel  = 8'd0;
	logic [7:0] second_channel = 8'd0;
	logic [7:0] third_channel  = 8'd0;
	logic       end_of_row     = 1'b0;
	logic       out_valid;
	logic       out_ready      = 1'b0;
	logic [7:0] blurred_gray;
	logic       row_done;
	logic       run_last;

	// predictor state
	logic [7:0]  gray_ring [RING_DEPTH];
	int unsigned ring_sum;
	int unsigned row_fill;
	int unsigned ring_slot;
	logic [7:0]  last_mean;
	logic [3:0]  radius_q;

	blur_word_t blurred_due [$];
	int         mismatch_count = 0;
	int         cycle_count    = 0;
	bit         no_idle        = 1'b0;
	bit         hold_off_req   = 1'b0;

	directed_row_t directed_rows [N_DIRECTED] = '{
		// one-pixel rows at both extremes
		'{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, 8'd255},
		'{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, 8'd0},
		// short row, one channel per pixel
		'{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, 8'd0},
		'{'{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, 8'd0},
		'{'{8'd0,   8'd0,   8'd255, 1'b1}, 1'b0, 8'd0},
		// white row one past the window: fill, first burst, slide, trailing
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, 8'd255},
		'{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, 8'd255},
		// short row of mixed values
		'{'{8'd12,  8'd200, 8'd77,  1'b0}, 1'b0, 8'd0},
		'{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, 8'd0},
		'{'{8'd255, 8'd0,   8'd255, 1'b0}, 1'b0, 8'd0},
		'{'{8'd1,   8'd2,   8'd3,   1'b0}, 1'b0, 8'd0},
		'{'{8'd90,  8'd180, 8'd45,  1'b1}, 1'b0, 8'd0}
	};

	gray_row_box_blur u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.first_channel (first_channel),
		.second_channel(second_channel),
		.third_channel (third_channel),
		.end_of_row    (end_of_row),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.blurred_gray  (blurred_gray),
		.row_done      (row_done),
		.run_last      (run_last)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (no_idle || sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] random_channel();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 8'd0;
		if (sel == 1)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.c0  = random_channel();
		px.c1  = random_channel();
		px.c2  = random_channel();
		px.eor = 1'b0;
		return px;
	endfunction

	// row lengths around the window length, short rows included
	function automatic int pick_row_length(input int len);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return len;
		if (sel < 15)
			return (len > 1) ? len - 1 : 1;
		if (sel < 35)
			return $urandom_range(1, len);
		return $urandom_range(len + 1, 3 * len + 6);
	endfunction

	function automatic void push_word(input logic [7:0] gray, inout int n);
		blur_word_t w;
		w.gray     = gray;
		w.row_done = 1'b0;
		w.run_last = 1'b0;
		blurred_due.push_back(w);
		n++;
	endfunction

	// gray conversion, window update and the words one pixel causes
	function automatic int blur_pixel(input pixel_t px);
		int unsigned r;
		int unsigned len;
		int unsigned g;
		int unsigned slot;
		int unsigned m;
		int          n;
		int          last;
		r    = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
		len  = 2 * r + 1;
		g    = (int'(W0) * px.c0 + int'(W1) * px.c1 + int'(W2) * px.c2) >> 16;
		if (g > 255)
			g = 255;
		slot = (ring_slot < len) ? ring_slot : 0;
		n    = 0;
		if (row_fill < len) begin
			gray_ring[slot] = 8'(g);
			ring_sum += g;
			row_fill++;
			// window just filled: leading pixels and first centre share its mean
			if (row_fill == len) begin
				last_mean = 8'(ring_sum / len);
				repeat (r + 1) push_word(last_mean, n);
			end
		end else begin
			ring_sum = ring_sum - gray_ring[slot] + g;
			gray_ring[slot] = 8'(g);
			last_mean = 8'(ring_sum / len);
			push_word(last_mean, n);
		end
		ring_sum  = ring_sum & 32'h1FFF;
		ring_slot = (slot + 1 >= len) ? 0 : slot + 1;
		last      = blurred_due.size() - 1;
		if (px.eor) begin
			if (row_fill >= len) begin
				repeat (r) push_word(last_mean, n);
			end else begin
				// short row: every position gets the mean of the whole row
				m = ring_sum / row_fill;
				repeat (row_fill) push_word(8'(m), n);
			end
			last = blurred_due.size() - 1;
			if (n > 0)
				blurred_due[last].row_done = 1'b1;
			ring_sum  = 0;
			row_fill  = 0;
			ring_slot = 0;
		end
		if (n > 0)
			blurred_due[last].run_last = 1'b1;
		return n;
	endfunction

	// offer one pixel and predict its words once it is taken
	task automatic send_pixel(input pixel_t px, input logic typed, input logic [7:0] gray);
		int gap;
		int n;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		first_channel  <= px.c0;
		second_channel <= px.c1;
		third_channel  <= px.c2;
		end_of_row     <= px.eor;
		do
			@(posedge clk);
		while (!in_ready);
		n = blur_pixel(px);
		if (typed) begin
			for (int i = blurred_due.size() - n; i < blurred_due.size(); i++) begin
				if (blurred_due[i].gray != gray)
					report_mismatch($sformatf("directed gray %0d, predicted %0d",
						gray, blurred_due[i].gray));
			end
		end
	endtask

	// drop valid, wait for every word, then let the back end go quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (blurred_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// a radius write also starts a new row
	task automatic write_radius(input logic [3:0] rad);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= rad;
		@(posedge clk);
		cfg_we    <= 1'b0;
		radius_q  = rad;
		ring_sum  = 0;
		row_fill  = 0;
		ring_slot = 0;
		last_mean = 8'd0;
	endtask

	// random rows at one radius; the phase may stop mid-row
	task automatic run_phase(input logic [3:0] rad, input int n_items, input bit quiet,
			input bit hold_off, input bit pause_mid);
		int     row_left;
		int     len;
		pixel_t px;
		write_radius(rad);
		len      = 2 * rad + 1;
		row_left = 0;
		no_idle  = quiet;
		if (hold_off)
			hold_off_req = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if (pause_mid && i == n_items / 2) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (blurred_due.size() != 0);
			end
			if (row_left == 0)
				row_left = pick_row_length(len);
			px     = random_pixel();
			px.eor = (row_left == 1);
			row_left--;
			send_pixel(px, 1'b0, 8'd0);
		end
		settle_block();
		no_idle = 1'b0;
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	// compare each accepted word with the oldest prediction
	always @(posedge clk) begin : check_words
		blur_word_t due;
		if (arst_n && out_valid && out_ready) begin
			if (blurred_due.size() == 0) begin
				report_mismatch($sformatf("word gray %0d with none due", blurred_gray));
			end else begin
				due = blurred_due.pop_front();
				if (blurred_gray !== due.gray)
					report_mismatch($sformatf("blurred_gray %0d, due %0d",
						blurred_gray, due.gray));
				if (row_done !== due.row_done)
					report_mismatch($sformatf("row_done %b, due %b", row_done, due.row_done));
				if (run_last !== due.run_last)
					report_mismatch($sformatf("run_last %b, due %b", run_last, due.run_last));
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// main sequence
	initial begin
		ring_sum  = 0;
		row_fill  = 0;
		ring_slot = 0;
		last_mean = 8'd0;
		radius_q  = 4'd5;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset radius
		for (int i = 0; i < N_DIRECTED; i++)
			send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].gray);
		settle_block();

		// random phases: extremes of the radius first
		run_phase(4'd0, 60, 1'b1, 1'b0, 1'b0);
		run_phase(4'd15, 120, 1'b0, 1'b1, 1'b0);
		run_phase(4'd1, 60, 1'b0, 1'b0, 1'b0);
		run_phase(4'd7, 80, 1'b0, 1'b0, 1'b1);
		run_phase(4'($urandom_range(2, 14)), 80, 1'b0, 1'b0, 1'b0);
		run_phase(4'($urandom_range(2, 14)), 100, 1'b0, 1'b1, 1'b0);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
